// ===== sv/aup_pkg.sv =====
// ----------------------------------------------------------------------------
// aup_pkg
// Shared types, constants and the divider step for the ARGB unpremultiply
// block.
// ----------------------------------------------------------------------------
package aup_pkg;

    localparam int CHAN_W             = 8;
    localparam int NUM_CHAN           = 3;
    localparam int DIV_BITS_PER_STAGE = 2;
    localparam int DIV_STAGES         = CHAN_W / DIV_BITS_PER_STAGE;
    // Stage 0 (operand capture) plus the divider stages
    localparam int LANE_LAT           = DIV_STAGES + 1;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

    // Lane positions
    localparam int LANE_RED   = 0;
    localparam int LANE_GREEN = 1;
    localparam int LANE_BLUE  = 2;

    // One divider pipeline stage: partial remainder, unconsumed low dividend
    // bits, divisor, quotient so far and the special-case marks.
    typedef struct packed {
        logic [CHAN_W-1:0] rem;
        logic [CHAN_W-1:0] low;
        logic [CHAN_W-1:0] div;
        logic [CHAN_W-1:0] quot;
        logic              zero;
        logic              over;
    } t_lane_stage;

    // What a lane hands to the merge stage
    typedef struct packed {
        logic [CHAN_W-1:0] chan;
        logic              bad;
    } t_lane_res;

    // Restoring division, DIV_BITS_PER_STAGE quotient bits per call.
    function automatic t_lane_stage div_stage(input t_lane_stage s_in);
        t_lane_stage     s;
        logic [CHAN_W:0] rem_ext;
        s = s_in;
        for (int j = 0; j < DIV_BITS_PER_STAGE; j++) begin
            rem_ext = {s.rem, s.low[CHAN_W-1]};
            s.low   = {s.low[CHAN_W-2:0], 1'b0};
            if (rem_ext >= {1'b0, s.div}) begin
                rem_ext = rem_ext - {1'b0, s.div};
                s.quot  = {s.quot[CHAN_W-2:0], 1'b1};
            end else begin
                s.quot  = {s.quot[CHAN_W-2:0], 1'b0};
            end
            s.rem = rem_ext[CHAN_W-1:0];
        end
        return s;
    endfunction

endpackage

// ===== sv/argb_unpremultiply.sv =====
// ----------------------------------------------------------------------------
// argb_unpremultiply
// Converts a premultiplied ARGB32 pixel to straight-alpha RGBA, saturating
// and flagging colors that exceed alpha.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  pixel in  input      start, busy           i_in_blue/green/red/alpha
//  pixel out output     o_strobe (no stall)   o_out_red/green/blue/alpha,
//                                             o_bad_premul
//
//  One pixel per clock; busy is always low.
//  Its stages are operand capture, four divider stages of two
//  quotient bits each (one per lane), and the merge register.
//  Three lanes (red, green, blue) run the divider side by side.
//  Reset clears only the valid line and the output strobe.
// ----------------------------------------------------------------------------
module argb_unpremultiply (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [aup_pkg::CHAN_W-1:0]       i_in_blue,
    input  logic [aup_pkg::CHAN_W-1:0]       i_in_green,
    input  logic [aup_pkg::CHAN_W-1:0]       i_in_red,
    input  logic [aup_pkg::CHAN_W-1:0]       i_in_alpha,
    output logic                             o_strobe,
    output logic [aup_pkg::CHAN_W-1:0]       o_out_red,
    output logic [aup_pkg::CHAN_W-1:0]       o_out_green,
    output logic [aup_pkg::CHAN_W-1:0]       o_out_blue,
    output logic [aup_pkg::CHAN_W-1:0]       o_out_alpha,
    output logic                             o_bad_premul
);
    import aup_pkg::*;

    logic [CHAN_W-1:0] w_chan [NUM_CHAN];
    t_lane_res         w_res  [NUM_CHAN];
    logic              r_vld  [LANE_LAT];
    logic [CHAN_W-1:0] r_alpha [LANE_LAT];

    assign busy = 1'b0;

    assign w_chan[LANE_RED]   = i_in_red;
    assign w_chan[LANE_GREEN] = i_in_green;
    assign w_chan[LANE_BLUE]  = i_in_blue;

    for (genvar g = 0; g < NUM_CHAN; g++) begin : g_lane
        aup_lane u_lane (
            .i_clk   (i_clk),
            .i_chan  (w_chan[g]),
            .i_alpha (i_in_alpha),
            .o_res   (w_res[g])
        );
    end

    // Track transactions and alpha alongside the lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LANE_LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            r_vld[0] <= start & ~busy;
            for (int k = 1; k < LANE_LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_alpha[0] <= i_in_alpha;
        for (int k = 1; k < LANE_LAT; k++) begin
            r_alpha[k] <= r_alpha[k-1];
        end
    end

    aup_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (r_vld[LANE_LAT-1]),
        .i_res    (w_res),
        .i_alpha  (r_alpha[LANE_LAT-1]),
        .o_strobe (o_strobe),
        .o_red    (o_out_red),
        .o_green  (o_out_green),
        .o_blue   (o_out_blue),
        .o_alpha  (o_out_alpha),
        .o_bad    (o_bad_premul)
    );

    // Every accepted transaction yields a result after the lanes and the merge register
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##6 o_strobe)
        else $error("accepted pixel produced no result");

    // Transparent pixels give black and no flag
    a_zero_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_out_alpha == '0) |->
            (o_out_red == '0 && o_out_green == '0 && o_out_blue == '0 && !o_bad_premul))
        else $error("zero alpha produced nonzero color or flag");

    // A flagged result must carry at least one saturated channel
    a_bad_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_bad_premul) |->
            (o_out_red == CHAN_MAX || o_out_green == CHAN_MAX || o_out_blue == CHAN_MAX))
        else $error("bad_premul without a saturated channel");

endmodule

// ===== sv/aup_lane.sv =====
// ----------------------------------------------------------------------------
// aup_lane
// One color channel: computes chan*255/alpha in a pipelined restoring
// divider and resolves the zero-alpha and over-alpha cases.
// ----------------------------------------------------------------------------
module aup_lane (
    input  logic                             i_clk,
    input  logic [aup_pkg::CHAN_W-1:0]       i_chan,
    input  logic [aup_pkg::CHAN_W-1:0]       i_alpha,
    output aup_pkg::t_lane_res               o_res
);
    import aup_pkg::*;

    t_lane_stage                r_stage [LANE_LAT];
    t_lane_stage                n_stage0;
    logic [2*CHAN_W-1:0]        w_prod;

    // chan * 255 as a shift and subtract
    assign w_prod = {i_chan, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, i_chan};

    always_comb begin
        n_stage0.rem  = w_prod[2*CHAN_W-1:CHAN_W];
        n_stage0.low  = w_prod[CHAN_W-1:0];
        n_stage0.div  = i_alpha;
        n_stage0.quot = '0;
        n_stage0.zero = (i_alpha == '0);
        n_stage0.over = (i_chan > i_alpha);
    end

    // Advance the operands one divider stage per clock
    always_ff @(posedge i_clk) begin
        r_stage[0] <= n_stage0;
        for (int k = 1; k < LANE_LAT; k++) begin
            r_stage[k] <= div_stage(r_stage[k-1]);
        end
    end

    // Zero alpha wins over the saturation case
    always_comb begin
        priority if (r_stage[LANE_LAT-1].zero) begin
            o_res.chan = '0;
            o_res.bad  = 1'b0;
        end else if (r_stage[LANE_LAT-1].over) begin
            o_res.chan = CHAN_MAX;
            o_res.bad  = 1'b1;
        end else begin
            o_res.chan = r_stage[LANE_LAT-1].quot;
            o_res.bad  = 1'b0;
        end
    end

endmodule

// ===== sv/aup_merge.sv =====
// ----------------------------------------------------------------------------
// aup_merge
// Collects the three lane results, combines their flags and registers the
// output transaction.
// ----------------------------------------------------------------------------
module aup_merge (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_vld,
    input  aup_pkg::t_lane_res               i_res [aup_pkg::NUM_CHAN],
    input  logic [aup_pkg::CHAN_W-1:0]       i_alpha,
    output logic                             o_strobe,
    output logic [aup_pkg::CHAN_W-1:0]       o_red,
    output logic [aup_pkg::CHAN_W-1:0]       o_green,
    output logic [aup_pkg::CHAN_W-1:0]       o_blue,
    output logic [aup_pkg::CHAN_W-1:0]       o_alpha,
    output logic                             o_bad
);
    import aup_pkg::*;

    logic r_strobe;
    logic n_bad;

    assign n_bad = i_res[LANE_RED].bad | i_res[LANE_GREEN].bad | i_res[LANE_BLUE].bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        o_red   <= i_res[LANE_RED].chan;
        o_green <= i_res[LANE_GREEN].chan;
        o_blue  <= i_res[LANE_BLUE].chan;
        o_alpha <= i_alpha;
        o_bad   <= n_bad;
    end

    assign o_strobe = r_strobe;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives premultiplied ARGB pixels into argb_unpremultiply and checks every
// straight-alpha result against an in-bench prediction, in arrival order.
// ----------------------------------------------------------------------------
module testbench;
    import aup_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = LANE_LAT + 6;

    typedef logic [CHAN_W-1:0] t_byte;

    typedef struct packed {
        t_byte red;
        t_byte green;
        t_byte blue;
        t_byte alpha;
        logic  bad;
    } t_straight_px;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  start = 1'b0;
    logic  busy;
    t_byte i_in_blue = '0;
    t_byte i_in_green = '0;
    t_byte i_in_red = '0;
    t_byte i_in_alpha = '0;
    logic  o_strobe;
    t_byte o_out_red;
    t_byte o_out_green;
    t_byte o_out_blue;
    t_byte o_out_alpha;
    logic  o_bad_premul;

    t_straight_px straight_q[$];
    int sender_idle_pct = 0;
    int pixels_sent = 0;
    int pixels_checked = 0;
    int flagged_seen = 0;
    int transparent_sent = 0;
    int mismatch_cnt = 0;
    int cycle_cnt = 0;

    argb_unpremultiply u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_in_blue    (i_in_blue),
        .i_in_green   (i_in_green),
        .i_in_red     (i_in_red),
        .i_in_alpha   (i_in_alpha),
        .o_strobe     (o_strobe),
        .o_out_red    (o_out_red),
        .o_out_green  (o_out_green),
        .o_out_blue   (o_out_blue),
        .o_out_alpha  (o_out_alpha),
        .o_bad_premul (o_bad_premul)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Straight color of one channel; flag colors above alpha.
    function automatic t_byte straight_chan(input t_byte c, input t_byte a, inout logic bad);
        logic [2*CHAN_W-1:0] scaled;
        if (a == '0) begin
            return '0;
        end
        if (c > a) begin
            bad = 1'b1;
            return CHAN_MAX;
        end
        scaled = ({8'd0, c} * {8'd0, CHAN_MAX}) / {8'd0, a};
        return scaled[CHAN_W-1:0];
    endfunction

    function automatic t_straight_px unpremul_pixel(input t_byte blue, input t_byte green,
                                                    input t_byte red, input t_byte alpha);
        t_straight_px px;
        logic bad;
        bad      = 1'b0;
        px.red   = straight_chan(red, alpha, bad);
        px.green = straight_chan(green, alpha, bad);
        px.blue  = straight_chan(blue, alpha, bad);
        px.alpha = alpha;
        px.bad   = bad;
        return px;
    endfunction

    // Hold the pixel on the bus until the block takes it.
    task automatic send_pixel(input t_byte blue, input t_byte green,
                              input t_byte red, input t_byte alpha);
        start      <= 1'b1;
        i_in_blue  <= blue;
        i_in_green <= green;
        i_in_red   <= red;
        i_in_alpha <= alpha;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        straight_q.push_back(unpremul_pixel(blue, green, red, alpha));
        pixels_sent++;
        if (alpha == '0) begin
            transparent_sent++;
        end
    endtask

    // Idle one cycle at a time so the idle share of cycles matches the rate.
    task automatic sender_gap();
        while ($urandom_range(99, 0) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Mostly well-formed premultiplied pixels, some transparent, some noise.
    task automatic send_random_pixel();
        t_byte chan[3];
        t_byte alpha;
        int    kind;
        kind = $urandom_range(99, 0);
        if (kind < 15) begin
            alpha = t_byte'($urandom_range(255, 0));
            foreach (chan[k]) chan[k] = t_byte'($urandom_range(255, 0));
        end else if (kind < 20) begin
            alpha = '0;
            foreach (chan[k]) chan[k] = ($urandom_range(1, 0) != 0) ? t_byte'(0)
                                                                    : t_byte'($urandom);
        end else begin
            alpha = ($urandom_range(3, 0) == 0) ? t_byte'($urandom_range(8, 1))
                                                : t_byte'($urandom_range(255, 1));
            foreach (chan[k]) begin
                if ($urandom_range(9, 0) == 0) begin
                    chan[k] = alpha;
                end else begin
                    chan[k] = t_byte'($urandom_range(alpha, 0));
                end
            end
            // Occasionally push one channel just past alpha.
            if (alpha != CHAN_MAX && $urandom_range(9, 0) == 0) begin
                chan[$urandom_range(2, 0)] = t_byte'($urandom_range(255, alpha + 1));
            end
        end
        send_pixel(chan[0], chan[1], chan[2], alpha);
    endtask

    task automatic test_corner_pixels();
        sender_idle_pct = 0;
        send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd0);
        send_pixel(8'd1, 8'd128, 8'd254, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
        send_pixel(8'd1, 8'd127, 8'd254, 8'd255);
        send_pixel(8'd0, 8'd1, 8'd0, 8'd1);
        send_pixel(8'd1, 8'd1, 8'd1, 8'd1);
        send_pixel(8'd1, 8'd0, 8'd2, 8'd2);
        send_pixel(8'd128, 8'd128, 8'd64, 8'd128);
        send_pixel(8'd200, 8'd100, 8'd10, 8'd100);
        send_pixel(8'd10, 8'd200, 8'd100, 8'd100);
        send_pixel(8'd100, 8'd10, 8'd200, 8'd100);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd1);
        send_pixel(8'd255, 8'd0, 8'd254, 8'd254);
        send_pixel(8'd85, 8'd170, 8'd3, 8'd171);
        send_pixel(8'd170, 8'd85, 8'd7, 8'd3);
        send_pixel(8'd37, 8'd99, 8'd211, 8'd212);
        start <= 1'b0;
    endtask

    task automatic test_sparse_sender(input int count);
        sender_idle_pct = 23;
        repeat (count) begin
            sender_gap();
            send_random_pixel();
        end
        start <= 1'b0;
    endtask

    task automatic test_bursty_sender(input int count);
        sender_idle_pct = 66;
        repeat (count) begin
            sender_gap();
            send_random_pixel();
        end
        start <= 1'b0;
    endtask

    task automatic test_back_to_back(input int count);
        sender_idle_pct = 0;
        repeat (count) send_random_pixel();
        start <= 1'b0;
    endtask

    function automatic void check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, exp_val, act_val);
            mismatch_cnt++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_straight_px exp_px;
        if (i_rst_n && o_strobe) begin
            if (straight_q.size() == 0) begin
                $display("%0t: result expected none actual red %0d green %0d blue %0d alpha %0d",
                         $time, o_out_red, o_out_green, o_out_blue, o_out_alpha);
                mismatch_cnt++;
            end else begin
                exp_px = straight_q.pop_front();
                check_field("red", exp_px.red, o_out_red);
                check_field("green", exp_px.green, o_out_green);
                check_field("blue", exp_px.blue, o_out_blue);
                check_field("alpha", exp_px.alpha, o_out_alpha);
                check_field("bad_premul", exp_px.bad, o_bad_premul);
                pixels_checked++;
                if (exp_px.bad) begin
                    flagged_seen++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, straight_q.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_corner_pixels();
        test_sparse_sender(600);
        test_bursty_sender(600);
        test_back_to_back(632);

        while (straight_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d of %0d pixels: %0d transparent, %0d saturated and flagged.",
                 pixels_checked, pixels_sent, transparent_sent, flagged_seen);
        $display("Sender idle rates 23%%, 66%% and none; %0d mismatching fields.",
                 mismatch_cnt);
        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
